### rtl/core/hex_record_parser_checksum_defines.svh
// Assertion macros for the record parser RTL.
`ifndef HEX_RECORD_PARSER_CHECKSUM_DEFINES_SVH
`define HEX_RECORD_PARSER_CHECKSUM_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define HRP_ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define HRP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/hrp_pkg.sv
// Shared types and constants of the record parser.
package hrp_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE    = 2'd0,
    ACT_DONE     = 2'd1,
    ACT_CSUM_ERR = 2'd2,
    ACT_LEN_ERR  = 2'd3
  } action_e;

  typedef enum logic {
    REG_WRITE_BASE    = 1'b0,
    REG_RECORD_STRIDE = 1'b1
  } reg_idx_e;

  localparam int unsigned AddrW   = 20;
  localparam int unsigned StrideW = 9;

  localparam logic [AddrW-1:0]   WriteBaseRst    = 20'h1A000;
  localparam logic [StrideW-1:0] RecordStrideRst = 9'd16;

  localparam logic [7:0] KindDone    = 8'h01;
  localparam logic [7:0] KindSkipLow = 8'h02;
  localparam logic [7:0] KindSkipHi  = 8'h05;

  typedef struct packed {
    logic take_byte;
    logic start_emit;
    logic emit_step;
  } hrp_cmd_t;

  typedef struct packed {
    logic emit_go;
    logic emit_last;
    logic slot_free;
  } hrp_status_t;

endpackage

### rtl/core/hex_record_parser_checksum.sv
// Top level: binary Intel HEX record parser with checksum check.
//
// Input channel (in_valid_i/in_ready_o) takes one record byte per item with a
// frame_start flag that clears a halt and restarts the record. Output channel
// (out_valid_o/out_ready_i) carries actions: byte writes, done, checksum error
// and length error, with last marking the final result of one input item.
// Two APB registers: write_base at 0x0 and record_stride at 0x4.
// Throughput: one input item per cycle while in_ready_o is high. Error and done
// results appear in the cycle after the causing item is taken. The checksum byte
// of a good data record blocks input until its writes are out: a prep state primes
// the buffer read port, then one write per cycle while the receiver takes them.
// Reset returns the parser to the length byte, clears the offset and halt,
// and loads the register defaults; the data buffer holds no reset value.
// When the receiver stalls, the output register holds its item and input
// ready drops until the register is taken.
module hex_record_parser_checksum
  import hrp_pkg::*;
#(
  parameter int unsigned MAX_DATA = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         action_o,
  output logic [AddrW-1:0]   flash_addr_o,
  output logic [7:0]         data_byte_o,
  output logic               last_o
);

  `include "hex_record_parser_checksum_defines.svh"

  logic [AddrW-1:0]   write_base_q;
  logic [StrideW-1:0] record_stride_q;
  reg_idx_e           reg_idx;
  hrp_cmd_t           cmd;
  hrp_status_t        status;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_comb begin
    case (reg_idx)
      REG_WRITE_BASE:    prdata = 32'(write_base_q);
      REG_RECORD_STRIDE: prdata = 32'(record_stride_q);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_base_q    <= WriteBaseRst;
      record_stride_q <= RecordStrideRst;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_WRITE_BASE:    write_base_q    <= pwdata[AddrW-1:0];
        REG_RECORD_STRIDE: record_stride_q <= pwdata[StrideW-1:0];
        default:           write_base_q    <= write_base_q;
      endcase
    end
  end

  hrp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hrp_dp #(
    .MAX_DATA (MAX_DATA)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_byte_i       (in_byte_i),
    .frame_start_i   (frame_start_i),
    .write_base_i    (write_base_q),
    .record_stride_i (record_stride_q),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .action_o        (action_o),
    .flash_addr_o    (flash_addr_o),
    .data_byte_o     (data_byte_o),
    .last_o          (last_o)
  );

  `HRP_ASSERT_IMPLIES(a_ready_needs_slot, clk_i, rst_ni, in_ready_o, !out_valid_o || out_ready_i, "input taken while output register blocked")
  `HRP_ASSERT_IMPLIES(a_ctl_fields_zero, clk_i, rst_ni, out_valid_o && (action_o != ACT_WRITE), (flash_addr_o == '0) && (data_byte_o == '0) && last_o, "control result with nonzero fields")
  `HRP_ASSERT_IMPLIES(a_burst_blocks_in, clk_i, rst_ni, out_valid_o && (action_o == ACT_WRITE) && !last_o, !in_ready_o, "input accepted inside a write burst")
  `HRP_ASSERT_NEXT(a_burst_continues, clk_i, rst_ni, out_valid_o && out_ready_i && (action_o == ACT_WRITE) && !last_o, out_valid_o || !in_ready_o, "write burst stopped before last")

endmodule

### rtl/core/hrp_ctrl.sv
// Controller: input handshake and write burst sequencing.
module hrp_ctrl
  import hrp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  hrp_status_t status_i,
  output hrp_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_EMIT
  } state_e;

  state_e state_q;

  assign in_ready_o       = (state_q == ST_IDLE) && status_i.slot_free;
  assign cmd_o.take_byte  = in_valid_i && in_ready_o;
  assign cmd_o.start_emit = cmd_o.take_byte && status_i.emit_go;
  assign cmd_o.emit_step  = (state_q == ST_EMIT) && status_i.slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.start_emit) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (cmd_o.emit_step && status_i.emit_last) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/hrp_dp.sv
// Datapath: record fields, running sum, data buffer and output register.
module hrp_dp
  import hrp_pkg::*;
#(
  parameter int unsigned MAX_DATA = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         in_byte_i,
  input  logic               frame_start_i,
  input  logic [AddrW-1:0]   write_base_i,
  input  logic [StrideW-1:0] record_stride_i,
  input  hrp_cmd_t           cmd_i,
  output hrp_status_t        status_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [1:0]         action_o,
  output logic [AddrW-1:0]   flash_addr_o,
  output logic [7:0]         data_byte_o,
  output logic               last_o
);

  localparam int unsigned CW = $clog2(MAX_DATA + 1);
  localparam int unsigned AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
  localparam logic [CW-1:0] MaxIdx = CW'(MAX_DATA);
  localparam logic [8:0]    MaxLen = 9'(MAX_DATA);

  typedef enum logic [2:0] {
    PH_LEN,
    PH_ADDR_HI,
    PH_ADDR_LO,
    PH_TYPE,
    PH_DATA,
    PH_CSUM
  } phase_e;

  phase_e            phase_q;
  logic [CW-1:0]     count_q;
  logic [CW-1:0]     len_q;
  logic [7:0]        kind_q;
  logic [7:0]        sum_q;
  logic [AddrW-1:0]  offset_q;
  logic              halted_q;
  logic [7:0]        mem [MAX_DATA];
  logic [7:0]        rd_q;
  logic [CW-1:0]     emit_idx_q;
  logic [AddrW-1:0]  emit_base_q;
  logic              out_valid_q;
  action_e           out_action_q;
  logic [AddrW-1:0]  out_addr_q;
  logic [7:0]        out_data_q;
  logic              out_last_q;

  phase_e        phase_eff;
  logic          active;
  logic [7:0]    sum_d;
  logic          len_big;
  logic          csum_ok;
  logic          kind_skip;
  logic          kind_done;
  logic          res_valid;
  action_e       res_action;
  logic [CW-1:0] count_d;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] rd_addr;

  assign phase_eff = frame_start_i ? PH_LEN : phase_q;
  assign active    = frame_start_i || !halted_q;
  assign sum_d     = sum_q + in_byte_i;
  assign len_big   = {1'b0, in_byte_i} > MaxLen;
  assign csum_ok   = (sum_d == 8'd0);
  assign kind_skip = (kind_q >= KindSkipLow) && (kind_q <= KindSkipHi);
  assign kind_done = (kind_q == KindDone);
  assign count_d   = count_q + CW'(1);
  assign idx_inc   = emit_idx_q + CW'(1);
  assign rd_addr   = cmd_i.emit_step ? idx_inc : emit_idx_q;

  always_comb begin
    res_valid  = 1'b0;
    res_action = ACT_LEN_ERR;
    if (active && (phase_eff == PH_LEN) && len_big) begin
      res_valid  = 1'b1;
      res_action = ACT_LEN_ERR;
    end else if (active && (phase_eff == PH_CSUM) && !csum_ok) begin
      res_valid  = 1'b1;
      res_action = ACT_CSUM_ERR;
    end else if (active && (phase_eff == PH_CSUM) && kind_done) begin
      res_valid  = 1'b1;
      res_action = ACT_DONE;
    end
  end

  assign status_o.emit_go   = active && (phase_eff == PH_CSUM) && csum_ok && !kind_skip &&
                              !kind_done && (len_q != '0);
  assign status_o.emit_last = (idx_inc == len_q);
  assign status_o.slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEN;
      count_q     <= '0;
      len_q       <= '0;
      kind_q      <= '0;
      sum_q       <= '0;
      offset_q    <= '0;
      halted_q    <= 1'b0;
      emit_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.take_byte && active) begin
        halted_q <= 1'b0;
        case (phase_eff)
          PH_LEN: begin
            len_q   <= in_byte_i[CW-1:0];
            sum_q   <= in_byte_i;
            count_q <= '0;
            if (len_big) begin
              halted_q <= 1'b1;
              phase_q  <= PH_LEN;
            end else begin
              phase_q <= PH_ADDR_HI;
            end
          end
          PH_ADDR_HI: begin
            sum_q   <= sum_d;
            phase_q <= PH_ADDR_LO;
          end
          PH_ADDR_LO: begin
            sum_q   <= sum_d;
            phase_q <= PH_TYPE;
          end
          PH_TYPE: begin
            sum_q   <= sum_d;
            kind_q  <= in_byte_i;
            phase_q <= (len_q == '0) ? PH_CSUM : PH_DATA;
          end
          PH_DATA: begin
            sum_q   <= sum_d;
            count_q <= count_d;
            if (count_d >= len_q) begin
              phase_q <= PH_CSUM;
            end
          end
          PH_CSUM: begin
            phase_q <= PH_LEN;
            if (!csum_ok || kind_done) begin
              halted_q <= 1'b1;
            end else if (!kind_skip) begin
              offset_q <= offset_q + AddrW'(record_stride_i);
            end
          end
          default: begin
            phase_q <= PH_LEN;
          end
        endcase
      end

      if (cmd_i.start_emit) begin
        emit_idx_q <= '0;
      end else if (cmd_i.emit_step) begin
        emit_idx_q <= idx_inc;
      end

      if (cmd_i.emit_step || (cmd_i.take_byte && res_valid)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte && active && (phase_eff == PH_DATA)) begin
      mem[count_q[AW-1:0]] <= in_byte_i;
    end
    if (rd_addr < MaxIdx) begin
      rd_q <= mem[rd_addr[AW-1:0]];
    end
    if (cmd_i.take_byte && active && (phase_eff == PH_CSUM)) begin
      emit_base_q <= write_base_i + offset_q;
    end
    if (cmd_i.emit_step) begin
      out_action_q <= ACT_WRITE;
      out_addr_q   <= emit_base_q + AddrW'(emit_idx_q);
      out_data_q   <= rd_q;
      out_last_q   <= status_o.emit_last;
    end else if (cmd_i.take_byte && res_valid) begin
      out_action_q <= res_action;
      out_addr_q   <= '0;
      out_data_q   <= '0;
      out_last_q   <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign action_o     = out_action_q;
  assign flash_addr_o = out_addr_q;
  assign data_byte_o  = out_data_q;
  assign last_o       = out_last_q;

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the binary HEX record parser with checksum check.
module tb;
  import hrp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxData      = 16;
  localparam int unsigned SettleCycles = 24;

  typedef enum {
    LEN_BYTE,
    ADDR_HI_BYTE,
    ADDR_LO_BYTE,
    KIND_BYTE,
    DATA_BYTES,
    SUM_BYTE
  } rec_step_e;

  typedef struct {
    action_e          act;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
    logic             last;
  } flash_cmd_t;

  class flash_cmd_tracker;
    logic [AddrW-1:0]   base;
    logic [StrideW-1:0] stride;
    rec_step_e          step;
    int unsigned        got;
    logic [7:0]         len;
    logic [7:0]         kind;
    logic [7:0]         sum;
    logic [7:0]         buffer [MaxData];
    logic [AddrW-1:0]   offset;
    bit                 halted;
    flash_cmd_t         pending_cmds [$];
    int unsigned        mismatches;

    function new();
      base       = WriteBaseRst;
      stride     = RecordStrideRst;
      step       = LEN_BYTE;
      got        = 0;
      len        = '0;
      kind       = '0;
      sum        = '0;
      offset     = '0;
      halted     = 1'b0;
      mismatches = 0;
    endfunction

    function void queue_cmd(action_e a, logic [AddrW-1:0] ad, logic [7:0] d, logic l);
      flash_cmd_t c;
      c.act  = a;
      c.addr = ad;
      c.data = d;
      c.last = l;
      pending_cmds.push_back(c);
    endfunction

    function void note_byte(logic [7:0] b, logic fs);
      logic [AddrW-1:0] start;
      if (fs) begin
        halted = 1'b0;
        step   = LEN_BYTE;
      end
      if (halted) return;
      case (step)
        LEN_BYTE: begin
          len = b;
          sum = b;
          got = 0;
          if (b > MaxData) begin
            queue_cmd(ACT_LEN_ERR, '0, '0, 1'b1);
            halted = 1'b1;
          end else begin
            step = ADDR_HI_BYTE;
          end
        end
        ADDR_HI_BYTE: begin
          sum  = sum + b;
          step = ADDR_LO_BYTE;
        end
        ADDR_LO_BYTE: begin
          sum  = sum + b;
          step = KIND_BYTE;
        end
        KIND_BYTE: begin
          sum  = sum + b;
          kind = b;
          step = (len == 0) ? SUM_BYTE : DATA_BYTES;
        end
        DATA_BYTES: begin
          sum = sum + b;
          if (got < MaxData) buffer[got] = b;
          got++;
          if (got >= len) step = SUM_BYTE;
        end
        default: begin
          step = LEN_BYTE;
          if (8'(sum + b) != 8'h00) begin
            queue_cmd(ACT_CSUM_ERR, '0, '0, 1'b1);
            halted = 1'b1;
          end else if (kind >= KindSkipLow && kind <= KindSkipHi) begin
            // address-type records carry nothing for flash
          end else if (kind == KindDone) begin
            queue_cmd(ACT_DONE, '0, '0, 1'b1);
            halted = 1'b1;
          end else begin
            start = base + offset;
            for (int unsigned j = 0; j < len; j++)
              queue_cmd(ACT_WRITE, AddrW'(start + j), buffer[j], j + 1 == len);
            offset = offset + AddrW'(stride);
          end
        end
      endcase
    endfunction

    task flag_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_cmd(logic [1:0] a, logic [AddrW-1:0] ad, logic [7:0] d, logic l);
      flash_cmd_t e;
      if (pending_cmds.size() == 0) begin
        flag_mismatch($sformatf("unexpected item action=%0d addr=%05h data=%02h last=%0b",
                                a, ad, d, l));
        return;
      end
      e = pending_cmds.pop_front();
      if (a !== e.act)
        flag_mismatch($sformatf("action %0d, want %s", a, e.act.name()));
      if (ad !== e.addr)
        flag_mismatch($sformatf("flash_addr %05h, want %05h", ad, e.addr));
      if (d !== e.data)
        flag_mismatch($sformatf("data_byte %02h, want %02h", d, e.data));
      if (l !== e.last)
        flag_mismatch($sformatf("last %0b, want %0b", l, e.last));
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni        = 1'b0;
  logic             psel          = 1'b0;
  logic             penable       = 1'b0;
  logic             pwrite        = 1'b0;
  logic [2:0]       paddr         = '0;
  logic [31:0]      pwdata        = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             in_valid_i    = 1'b0;
  logic             in_ready_o;
  logic [7:0]       in_byte_i     = '0;
  logic             frame_start_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i   = 1'b0;
  logic [1:0]       action_o;
  logic [AddrW-1:0] flash_addr_o;
  logic [7:0]       data_byte_o;
  logic             last_o;

  flash_cmd_tracker tracker;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_idle_pct = 0;
  int unsigned      bytes_sent    = 0;
  bit               need_fs       = 1'b1;
  logic [7:0]       none [$];

  hex_record_parser_checksum #(.MAX_DATA(MaxData)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .action_o      (action_o),
    .flash_addr_o  (flash_addr_o),
    .data_byte_o   (data_byte_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("hex_record_parser_checksum regression: fail");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_cmd(action_o, flash_addr_o, data_byte_o, last_o);
  end

  task automatic push_byte(logic [7:0] b, logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_byte_i     <= b;
    frame_start_i <= fs;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_byte(b, fs);
    bytes_sent++;
  endtask

  task automatic send_record(logic fs, logic [7:0] len, logic [7:0] kind,
                             logic [7:0] data [$], bit bad);
    logic [7:0] sum;
    logic [7:0] b;
    sum = len;
    push_byte(len, fs);
    if (len > MaxData) return;
    repeat (2) begin
      b   = 8'($urandom_range(255));
      sum = sum + b;
      push_byte(b, 1'b0);
    end
    sum = sum + kind;
    push_byte(kind, 1'b0);
    foreach (data[i]) begin
      sum = sum + data[i];
      push_byte(data[i], 1'b0);
    end
    b = -sum;
    if (bad) b = b ^ 8'($urandom_range(1, 255));
    push_byte(b, 1'b0);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (tracker.pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_idx_e idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_WRITE_BASE) tracker.base = val[AddrW-1:0];
    else tracker.stride = val[StrideW-1:0];
    @(posedge clk_i);
  endtask

  task automatic random_traffic(int unsigned goal);
    int unsigned r;
    logic [7:0]  len;
    logic [7:0]  kind;
    logic [7:0]  data [$];
    bit          bad;
    logic        fs;
    while (bytes_sent < goal) begin
      r = $urandom_range(99);
      if (r < 3) begin
        wait_drained();
      end else if (r < 9) begin
        push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        need_fs = 1'b1;
      end else begin
        r = $urandom_range(99);
        if (r < 6) len = 8'($urandom_range(MaxData + 1, 255));
        else if (r < 14) len = 8'(MaxData);
        else len = 8'($urandom_range(0, MaxData));
        r = $urandom_range(99);
        if (r < 62) kind = 8'h00;
        else if (r < 70) kind = KindDone;
        else if (r < 82) kind = 8'($urandom_range(KindSkipLow, KindSkipHi));
        else kind = 8'($urandom_range(6, 255));
        data.delete();
        if (len <= MaxData)
          repeat (len) data.push_back(8'($urandom_range(255)));
        bad = ($urandom_range(99) < 8);
        fs  = need_fs | 1'($urandom_range(1));
        send_record(fs, len, kind, data, bad);
        need_fs = bad || (len > MaxData) || (kind == KindDone);
      end
    end
  endtask

  initial begin
    tracker = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 21;
    recv_idle_pct = 56;
    send_record(1'b1, 8'd2, 8'h00, '{8'h00, 8'hFF}, 1'b0);
    send_record(1'b0, 8'd0, 8'h03, none, 1'b0);
    send_record(1'b0, 8'd0, 8'h00, none, 1'b0);
    send_record(1'b0, 8'd1, 8'hFF, '{8'h5A}, 1'b0);
    send_record(1'b0, 8'd0, 8'h00, none, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'(MaxData + 1), 1'b1);
    push_byte(8'hFF, 1'b1);
    send_record(1'b1, 8'd0, KindDone, none, 1'b0);
    need_fs = 1'b1;
    random_traffic(bytes_sent + 75);
    wait_drained();

    send_idle_pct = 56;
    recv_idle_pct = 21;
    apb_write(REG_WRITE_BASE, 32'h000F_FFF8);
    apb_write(REG_RECORD_STRIDE, 32'd0);
    random_traffic(bytes_sent + 75);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    apb_write(REG_WRITE_BASE, 32'h0000_0000);
    apb_write(REG_RECORD_STRIDE, 32'd256);
    random_traffic(bytes_sent + 75);
    wait_drained();

    apb_write(REG_WRITE_BASE, 32'($urandom_range(0, 20'hFFFFF)));
    apb_write(REG_RECORD_STRIDE, 32'd1);
    random_traffic(bytes_sent + 75);
    wait_drained();

    if (tracker.pending_cmds.size() != 0)
      tracker.flag_mismatch($sformatf("%0d items never arrived", tracker.pending_cmds.size()));
    if (tracker.mismatches == 0) begin
      $display("hex_record_parser_checksum regression: pass");
    end else begin
      $display("hex_record_parser_checksum regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/hrp_pkg.sv
rtl/core/hrp_ctrl.sv
rtl/core/hrp_dp.sv
rtl/core/hex_record_parser_checksum.sv
tb/sv/tb.sv
